@@ design/rcpwm_pkg.sv @@
package rcpwm_pkg;

  localparam int MAX_CH      = 5;
  localparam int CHANNELS_DEF = 5;
  localparam int VAL_W       = 16;
  localparam int TIME_W      = 32;
  localparam int PINS_W      = 5;
  localparam int ERR_W       = 6;
  localparam int ADDR_W      = 3;
  localparam int APB_W       = 32;

  // stream word widths, padded to whole bytes
  localparam int S_TDATA_W = 40;   // 5 + 32 -> 40
  localparam int M_TDATA_W = 168;  // 10*16 + 1 -> 168

  localparam logic [VAL_W-1:0] PERIOD_LIMIT_RST = 16'd8000;
  localparam logic [ERR_W-1:0] ERROR_LIMIT_RST  = 6'd50;
  localparam logic [ERR_W-1:0] ERR_TOP          = 6'd63;
  localparam logic [VAL_W-1:0] VAL_MAX          = 16'hFFFF;

  // register index, taken from paddr[2]
  localparam logic REG_PERIOD_LIMIT = 1'b0;
  localparam logic REG_ERROR_LIMIT  = 1'b1;

  // per-sample event from a channel to the shared error counter
  typedef struct packed {
    logic             start;
    logic [VAL_W-1:0] period;
  } chan_evt_t;

endpackage

@@ design/rcpwm_channel.sv @@
module rcpwm_channel (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           load,
  input  logic                           level,
  input  logic [rcpwm_pkg::TIME_W-1:0]   time_us,
  output logic [rcpwm_pkg::VAL_W-1:0]    width,
  output logic [rcpwm_pkg::VAL_W-1:0]    period,
  output rcpwm_pkg::chan_evt_t           evt
);

  logic [rcpwm_pkg::TIME_W-1:0] start_stamp;
  logic                         in_cycle;
  logic [rcpwm_pkg::TIME_W-1:0] elapsed;
  logic [rcpwm_pkg::VAL_W-1:0]  elapsed_sat;
  logic [rcpwm_pkg::VAL_W-1:0]  width_next;
  logic [rcpwm_pkg::VAL_W-1:0]  period_next;

  // one subtractor serves both: period on a start, width on a low sample
  assign elapsed     = time_us - start_stamp;
  assign elapsed_sat = (elapsed[rcpwm_pkg::TIME_W-1:rcpwm_pkg::VAL_W] != '0) ?
                       rcpwm_pkg::VAL_MAX : elapsed[rcpwm_pkg::VAL_W-1:0];

  assign evt.start  = level && !in_cycle;
  assign evt.period = elapsed_sat;

  always_comb begin
    width_next  = width;
    period_next = period;
    if (evt.start) begin
      width_next  = '0;
      period_next = elapsed_sat;
    end else if (!level && width == '0) begin
      width_next = elapsed_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_stamp <= '0;
      in_cycle    <= 1'b0;
      width       <= '0;
      period      <= '0;
    end else if (load) begin
      in_cycle <= level;
      width    <= width_next;
      period   <= period_next;
      if (evt.start) begin
        start_stamp <= time_us;
      end
    end
  end

endmodule

@@ design/rc_pwm_pulse_capture.sv @@
// An accepted input word's result word appears on m_tdata in the next cycle.
// Throughput: 1 word per cycle; the channel state registers are the result
// register, so a new word is taken whenever the result slot is free or drains.
// The error counter chain runs combinationally through all channels (<= 5 steps).
// Reset (rst, synchronous): clears all channel state, the error counter and
// m_tvalid; limits return to 8000 us and 50.
module rc_pwm_pulse_capture #(
  parameter int CHANNELS = rcpwm_pkg::CHANNELS_DEF  // 1..5
) (
  input  logic                               clk,
  input  logic                               rst,
  // input stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [rcpwm_pkg::S_TDATA_W-1:0]    s_tdata,  // pin_levels[4:0], time_us[36:5]
  // result stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // width_ch0..4 [79:0], period_ch0..4 [159:80], reboot_request [160]
  output logic [rcpwm_pkg::M_TDATA_W-1:0]    m_tdata,
  // config port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [rcpwm_pkg::ADDR_W-1:0]       paddr,
  input  logic [rcpwm_pkg::APB_W-1:0]        pwdata,
  output logic [rcpwm_pkg::APB_W-1:0]        prdata,
  output logic                               pready
);

  // ---------------------------------------------------------------------
  // Config registers
  // ---------------------------------------------------------------------
  logic [rcpwm_pkg::VAL_W-1:0] period_limit;
  logic [rcpwm_pkg::ERR_W-1:0] error_limit;
  logic                        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      period_limit <= rcpwm_pkg::PERIOD_LIMIT_RST;
      error_limit  <= rcpwm_pkg::ERROR_LIMIT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        rcpwm_pkg::REG_PERIOD_LIMIT: period_limit <= pwdata[rcpwm_pkg::VAL_W-1:0];
        rcpwm_pkg::REG_ERROR_LIMIT:  error_limit  <= pwdata[rcpwm_pkg::ERR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      rcpwm_pkg::REG_PERIOD_LIMIT:
        prdata = {{(rcpwm_pkg::APB_W-rcpwm_pkg::VAL_W){1'b0}}, period_limit};
      rcpwm_pkg::REG_ERROR_LIMIT:
        prdata = {{(rcpwm_pkg::APB_W-rcpwm_pkg::ERR_W){1'b0}}, error_limit};
      default: prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Handshake: result slot frees when downstream takes the word
  // ---------------------------------------------------------------------
  logic                                  accept;
  logic [rcpwm_pkg::PINS_W-1:0]          pin_levels;
  logic [rcpwm_pkg::TIME_W-1:0]          time_us;

  assign s_tready   = !m_tvalid || m_tready;
  assign accept     = s_tvalid && s_tready;
  assign pin_levels = s_tdata[rcpwm_pkg::PINS_W-1:0];
  assign time_us    = s_tdata[rcpwm_pkg::PINS_W +: rcpwm_pkg::TIME_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------
  // Channels; unused ones read as zero
  // ---------------------------------------------------------------------
  logic [rcpwm_pkg::VAL_W-1:0] width_ch  [rcpwm_pkg::MAX_CH];
  logic [rcpwm_pkg::VAL_W-1:0] period_ch [rcpwm_pkg::MAX_CH];
  rcpwm_pkg::chan_evt_t        evt       [CHANNELS];

  for (genvar i = 0; i < rcpwm_pkg::MAX_CH; i++) begin : g_ch
    if (i < CHANNELS) begin : g_used
      rcpwm_channel u_ch (
        .clk     (clk),
        .rst     (rst),
        .load    (accept),
        .level   (pin_levels[i]),
        .time_us (time_us),
        .width   (width_ch[i]),
        .period  (period_ch[i]),
        .evt     (evt[i])
      );
    end else begin : g_unused
      assign width_ch[i]  = '0;
      assign period_ch[i] = '0;
    end
  end

  // ---------------------------------------------------------------------
  // Shared leaky error counter: starts are applied in channel order
  // ---------------------------------------------------------------------
  logic [rcpwm_pkg::ERR_W-1:0] error_level;
  logic [rcpwm_pkg::ERR_W-1:0] error_level_next;
  logic                        reboot_next;
  logic                        reboot_request;

  always_comb begin
    error_level_next = error_level;
    reboot_next      = 1'b0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (evt[i].start) begin
        if (evt[i].period > period_limit) begin
          if (error_level_next != rcpwm_pkg::ERR_TOP) begin
            error_level_next = error_level_next + 1'b1;
          end
        end else if (error_level_next != '0) begin
          error_level_next = error_level_next - 1'b1;
        end
        if (error_level_next > error_limit) begin
          error_level_next = '0;
          reboot_next      = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      error_level    <= '0;
      reboot_request <= 1'b0;
    end else if (accept) begin
      error_level    <= error_level_next;
      reboot_request <= reboot_next;
    end
  end

  // ---------------------------------------------------------------------
  // Result word packing
  // ---------------------------------------------------------------------
  always_comb begin
    m_tdata = '0;
    for (int i = 0; i < rcpwm_pkg::MAX_CH; i++) begin
      m_tdata[i*rcpwm_pkg::VAL_W +: rcpwm_pkg::VAL_W] = width_ch[i];
      m_tdata[(rcpwm_pkg::MAX_CH+i)*rcpwm_pkg::VAL_W +: rcpwm_pkg::VAL_W] = period_ch[i];
    end
    m_tdata[2*rcpwm_pkg::MAX_CH*rcpwm_pkg::VAL_W] = reboot_request;
  end

`ifndef SYNTHESIS
  // an accepted word always shows up as a pending result
  a_accept_valid: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_tvalid)
    else $error("result not pending after accept");

  // input stalls only behind a waiting result
  a_stall_reason: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with empty result slot");

  // error counter moves only on an accepted word
  a_err_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(error_level))
    else $error("error counter changed without input");

  // no cycle start, no reboot request
  a_reboot_cause: assert property (@(posedge clk) disable iff (rst)
    (accept && pin_levels == '0) |=> !reboot_request)
    else $error("reboot request without cycle start");
`endif

endmodule
